// File: src/wpa_pkg.sv
// ----------------------------------------------------------------------------
// wpa_pkg: shared types and constants of the weighted pixel accumulator
// Request and response payloads, register indexes, status codes, divider
// request bundle and fixed-point limits.
// ----------------------------------------------------------------------------
`default_nettype none

package wpa_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_BAND_LANES = 4;

    localparam int OUT_LANES = 4;
    localparam int SUM_W     = 48;
    localparam int CNT_W     = 32;
    localparam int WSUM_W    = 32;
    localparam int DIV_NUM_W = 61;
    localparam int DIV_DEN_W = 33;
    localparam int DIV_MAG_W = 60;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BANDS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y    = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAND_ERR = 2'd1;
    localparam logic [1:0] ST_IDX_ERR  = 2'd2;

    localparam logic KIND_ADD     = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    localparam logic signed [SUM_W-1:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] S48_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic              kind;
        logic [7:0]        pos_x;
        logic [7:0]        pos_y;
        logic [2:0]        band_count;
        logic signed [15:0] sample_weight;
        logic signed [15:0] value0;
        logic signed [15:0] value1;
        logic signed [15:0] value2;
        logic signed [15:0] value3;
        logic              divide_by_count;
        logic              divide_by_weight;
    } t_req;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [SUM_W-1:0] band_out0;
        logic signed [SUM_W-1:0] band_out1;
        logic signed [SUM_W-1:0] band_out2;
        logic signed [SUM_W-1:0] band_out3;
    } t_rsp;

    typedef struct packed {
        logic                        start;
        logic signed [DIV_NUM_W-1:0] num;
        logic signed [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                        done;
        logic signed [DIV_NUM_W-1:0] quo;
    } t_div_rsp;

endpackage

`default_nettype wire

// File: src/wpa_store.sv
// ----------------------------------------------------------------------------
// wpa_store: per-pixel accumulation memory
// One row per pixel, registered read, one write port, zero sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module wpa_store #(
    parameter int DEPTH = 65536,
    parameter int ROW_W = 256,
    parameter int ADDR_W = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    output logic                   o_clr_busy,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic [ROW_W-1:0]       o_rd_data,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [ROW_W-1:0]  i_wr_data
);

    logic [ROW_W-1:0]  mem [DEPTH];
    logic [ROW_W-1:0]  r_rd_data;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_clr_busy = r_clr_busy;
    assign o_rd_data  = r_rd_data;

endmodule

`default_nettype wire

// File: src/wpa_div.sv
// ----------------------------------------------------------------------------
// wpa_div: shared iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, quotient
// truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module wpa_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wpa_pkg::t_div_req i_req,
    output wpa_pkg::t_div_rsp      o_rsp
);

    localparam int MW = wpa_pkg::DIV_MAG_W;
    localparam int DW = wpa_pkg::DIV_DEN_W - 1;
    localparam int CW = $clog2(MW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_steps;
    logic          r_neg;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [MW-1:0] r_quo;

    logic [wpa_pkg::DIV_NUM_W-1:0] num_mag;
    logic [wpa_pkg::DIV_DEN_W-1:0] den_mag;
    logic [DW:0]                   trial;
    logic                          take;
    logic [wpa_pkg::DIV_NUM_W-1:0] quo_ext;

    always_comb begin
        num_mag = i_req.num[wpa_pkg::DIV_NUM_W-1] ? -i_req.num : i_req.num;
        den_mag = i_req.den[wpa_pkg::DIV_DEN_W-1] ? -i_req.den : i_req.den;
        trial   = {r_rem, r_quo[MW-1]};
        take    = trial >= {1'b0, r_den};
        quo_ext = {1'b0, r_quo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_steps <= CW'(MW);
                r_neg   <= i_req.num[wpa_pkg::DIV_NUM_W-1] ^ i_req.den[wpa_pkg::DIV_DEN_W-1];
                r_den   <= den_mag[DW-1:0];
                r_rem   <= '0;
                r_quo   <= num_mag[MW-1:0];
            end else if (r_busy) begin
                r_rem   <= take ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
                r_quo   <= {r_quo[MW-2:0], take};
                r_steps <= r_steps - 1'b1;
                if (r_steps == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? -quo_ext : quo_ext;

endmodule

`default_nettype wire

// File: src/weighted_pixel_accumulator.sv
// ----------------------------------------------------------------------------
// weighted_pixel_accumulator: per-pixel weighted spectral accumulation store
// Sequencer over a pixel memory, a shared multiplier and a shared divider.
// ----------------------------------------------------------------------------
// Each pixel holds a sample count, a weight sum and one 48-bit band sum per
// lane, all in one memory row. An add request reads the row, bumps the count,
// adds the weight (saturating), then for a nonzero weight walks the lanes one
// at a time: a 16x16 multiply step and a round/accumulate step per lane,
// then writes the row back. An extract request reads the row and walks the
// lanes in use (at most four); each lane may go through the shared 60-step
// divider once for the count and once for the weight sum. Error requests go
// straight to the response. The block takes one request at a time and drops
// ready until the response has been taken; the next request can be taken in
// the cycle after that. After reset the memory is swept to zero, one row per
// cycle over all MAX_WIDTH*MAX_HEIGHT rows, during which no request is taken;
// register writes work at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_pixel_accumulator #(
    parameter int MAX_WIDTH  = wpa_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = wpa_pkg::DEF_MAX_HEIGHT,
    parameter int BAND_LANES = wpa_pkg::DEF_BAND_LANES
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_req_valid,
    output logic                                o_req_ready,
    input  wire wpa_pkg::t_req                  i_req,
    output logic                                o_rsp_valid,
    input  wire logic                           i_rsp_ready,
    output wpa_pkg::t_rsp                       o_rsp,
    input  wire logic                           i_cfg_we,
    input  wire logic [wpa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [wpa_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PIX_N  = MAX_WIDTH * MAX_HEIGHT;
    localparam int PIX_W  = (PIX_N > 1) ? $clog2(PIX_N) : 1;
    localparam int SW     = wpa_pkg::SUM_W;
    localparam int ROW_W  = wpa_pkg::CNT_W + wpa_pkg::WSUM_W + SW * BAND_LANES;
    localparam int LANE_W = $clog2(BAND_LANES) + 1;
    localparam int LIDX_W = (BAND_LANES > 1) ? $clog2(BAND_LANES) : 1;
    localparam int BASE   = wpa_pkg::CNT_W + wpa_pkg::WSUM_W;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_LOAD    = 9'b000000010,
        S_ADD_MUL = 9'b000000100,
        S_ADD_ACC = 9'b000001000,
        S_WRITE   = 9'b000010000,
        S_EX_LANE = 9'b000100000,
        S_EX_DIVN = 9'b001000000,
        S_EX_DIVW = 9'b010000000,
        S_OUT     = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [2:0] r_num_bands;
    logic [8:0] r_size_x;
    logic [8:0] r_size_y;

    // request context
    wpa_pkg::t_req      r_req, n_req;
    logic [PIX_W-1:0]   r_pix, n_pix;
    logic [LANE_W-1:0]  r_lane, n_lane;
    logic [LANE_W-1:0]  r_lim, n_lim;
    logic [1:0]         r_status, n_status;

    // working copy of the pixel row
    logic [wpa_pkg::CNT_W-1:0]         r_cnt, n_cnt;
    logic signed [wpa_pkg::WSUM_W-1:0] r_ws, n_ws;
    logic signed [SW-1:0]              r_band [BAND_LANES];
    logic signed [SW-1:0]              n_band [BAND_LANES];
    logic signed [31:0]                r_prod, n_prod;
    logic signed [SW-1:0]              r_res [wpa_pkg::OUT_LANES];
    logic signed [SW-1:0]              n_res [wpa_pkg::OUT_LANES];

    // memory and divider hookup
    logic              clr_busy;
    logic [ROW_W-1:0]  rd_data;
    logic              wr_en;
    logic [ROW_W-1:0]  wr_data;
    logic [PIX_W-1:0]  rd_addr;
    wpa_pkg::t_div_req div_req;
    wpa_pkg::t_div_rsp div_rsp;

    wpa_store #(
        .DEPTH (PIX_N),
        .ROW_W (ROW_W),
        .ADDR_W(PIX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_clr_busy(clr_busy),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_pix),
        .i_wr_data (wr_data)
    );

    wpa_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    function automatic logic signed [SW-1:0] sat48(input logic signed [wpa_pkg::DIV_NUM_W-1:0] v);
        if (v > wpa_pkg::DIV_NUM_W'(wpa_pkg::S48_MAX)) begin
            return wpa_pkg::S48_MAX;
        end else if (v < wpa_pkg::DIV_NUM_W'(wpa_pkg::S48_MIN)) begin
            return wpa_pkg::S48_MIN;
        end
        return v[SW-1:0];
    endfunction

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_bands <= '0;
            r_size_x    <= '0;
            r_size_y    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wpa_pkg::CFG_NUM_BANDS: r_num_bands <= i_cfg_data[2:0];
                wpa_pkg::CFG_SIZE_X:    r_size_x    <= i_cfg_data;
                wpa_pkg::CFG_SIZE_Y:    r_size_y    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic                    accept;
    logic                    band_bad;
    logic                    idx_bad;
    int                      lanes_i;
    logic signed [15:0]      lane_val;
    logic [LIDX_W-1:0]       lidx;
    logic [1:0]              ridx;
    logic signed [SW-1:0]    cur_band;
    logic signed [32:0]      rnd;
    logic signed [SW:0]      acc;
    logic [wpa_pkg::CNT_W-1:0]         rd_cnt;
    logic signed [wpa_pkg::WSUM_W-1:0] rd_ws;
    logic signed [wpa_pkg::WSUM_W:0]   ws_sum;
    logic                    by_n;
    logic                    by_w;
    logic signed [wpa_pkg::DIV_NUM_W-1:0] wnum_band;
    logic signed [wpa_pkg::DIV_NUM_W-1:0] wnum_quo;

    always_comb begin
        accept   = i_req_valid && o_req_ready;
        band_bad = (i_req.kind == wpa_pkg::KIND_ADD) && (i_req.band_count != r_num_bands);
        idx_bad  = (32'(i_req.pos_x) >= 32'(r_size_x)) || (32'(i_req.pos_x) >= MAX_WIDTH) ||
                   (32'(i_req.pos_y) >= 32'(r_size_y)) || (32'(i_req.pos_y) >= MAX_HEIGHT);
        rd_addr  = PIX_W'(32'(i_req.pos_y) * MAX_WIDTH + 32'(i_req.pos_x));
        lanes_i  = (32'(r_num_bands) < BAND_LANES) ? 32'(r_num_bands) : BAND_LANES;

        lidx     = LIDX_W'(r_lane);
        ridx     = 2'(r_lane);
        cur_band = r_band[lidx];
        case (r_lane)
            LANE_W'(0): lane_val = r_req.value0;
            LANE_W'(1): lane_val = r_req.value1;
            LANE_W'(2): lane_val = r_req.value2;
            LANE_W'(3): lane_val = r_req.value3;
            default:    lane_val = '0;
        endcase
        // round off 12 fraction bits, arithmetic shift floors
        rnd = (33'(r_prod) + 33'sd2048) >>> 12;
        acc = {cur_band[SW-1], cur_band} + (SW+1)'(rnd);

        rd_cnt = rd_data[wpa_pkg::CNT_W-1:0];
        rd_ws  = rd_data[BASE-1:wpa_pkg::CNT_W];
        ws_sum = {rd_ws[wpa_pkg::WSUM_W-1], rd_ws} + (wpa_pkg::WSUM_W+1)'(r_req.sample_weight);

        by_n      = r_req.divide_by_count && (r_cnt != '0);
        by_w      = r_req.divide_by_weight && (r_ws != '0);
        wnum_band = wpa_pkg::DIV_NUM_W'(cur_band) <<< 12;
        wnum_quo  = wpa_pkg::DIV_NUM_W'($signed(div_rsp.quo[SW-1:0])) <<< 12;

        wr_data = '0;
        wr_data[wpa_pkg::CNT_W-1:0] = r_cnt;
        wr_data[BASE-1:wpa_pkg::CNT_W] = r_ws;
        for (int i = 0; i < BAND_LANES; i++) begin
            wr_data[BASE + SW*i +: SW] = r_band[i];
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_pix    = r_pix;
        n_lane   = r_lane;
        n_lim    = r_lim;
        n_status = r_status;
        n_cnt    = r_cnt;
        n_ws     = r_ws;
        n_prod   = r_prod;
        n_band   = r_band;
        n_res    = r_res;
        wr_en    = 1'b0;
        div_req  = '{start: 1'b0, num: '0, den: '0};

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req  = i_req;
                    n_pix  = rd_addr;
                    n_lane = '0;
                    for (int i = 0; i < wpa_pkg::OUT_LANES; i++) begin
                        n_res[i] = '0;
                    end
                    if (i_req.kind == wpa_pkg::KIND_EXTRACT && lanes_i > wpa_pkg::OUT_LANES) begin
                        n_lim = LANE_W'(wpa_pkg::OUT_LANES);
                    end else begin
                        n_lim = LANE_W'(lanes_i);
                    end
                    if (band_bad) begin
                        n_status = wpa_pkg::ST_BAND_ERR;
                        n_state  = S_OUT;
                    end else if (idx_bad) begin
                        n_status = wpa_pkg::ST_IDX_ERR;
                        n_state  = S_OUT;
                    end else begin
                        n_status = wpa_pkg::ST_OK;
                        n_state  = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                for (int i = 0; i < BAND_LANES; i++) begin
                    n_band[i] = rd_data[BASE + SW*i +: SW];
                end
                if (r_req.kind == wpa_pkg::KIND_ADD) begin
                    n_cnt = (&rd_cnt) ? rd_cnt : rd_cnt + 1'b1;
                    if (ws_sum > 33'sh0_7FFF_FFFF) begin
                        n_ws = 32'sh7FFF_FFFF;
                    end else if (ws_sum < -33'sh0_8000_0000) begin
                        n_ws = 32'sh8000_0000;
                    end else begin
                        n_ws = ws_sum[wpa_pkg::WSUM_W-1:0];
                    end
                    if (r_req.sample_weight == '0 || r_lim == '0) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_ADD_MUL;
                    end
                end else begin
                    n_cnt   = rd_cnt;
                    n_ws    = rd_ws;
                    n_state = S_EX_LANE;
                end
            end
            S_ADD_MUL: begin
                n_prod  = r_req.sample_weight * lane_val;
                n_state = S_ADD_ACC;
            end
            S_ADD_ACC: begin
                if (acc > (SW+1)'(wpa_pkg::S48_MAX)) begin
                    n_band[lidx] = wpa_pkg::S48_MAX;
                end else if (acc < (SW+1)'(wpa_pkg::S48_MIN)) begin
                    n_band[lidx] = wpa_pkg::S48_MIN;
                end else begin
                    n_band[lidx] = acc[SW-1:0];
                end
                n_lane  = r_lane + 1'b1;
                n_state = (r_lane + 1'b1 == r_lim) ? S_WRITE : S_ADD_MUL;
            end
            S_WRITE: begin
                wr_en   = 1'b1;
                n_state = S_OUT;
            end
            S_EX_LANE: begin
                if (r_lane == r_lim) begin
                    n_state = S_OUT;
                end else if (by_n) begin
                    div_req = '{start: 1'b1,
                                num: wpa_pkg::DIV_NUM_W'(cur_band),
                                den: {1'b0, r_cnt}};
                    n_state = S_EX_DIVN;
                end else if (by_w) begin
                    div_req = '{start: 1'b1, num: wnum_band,
                                den: wpa_pkg::DIV_DEN_W'(r_ws)};
                    n_state = S_EX_DIVW;
                end else begin
                    n_res[ridx] = cur_band;
                    n_lane      = r_lane + 1'b1;
                end
            end
            S_EX_DIVN: begin
                if (div_rsp.done) begin
                    if (by_w) begin
                        div_req = '{start: 1'b1, num: wnum_quo,
                                    den: wpa_pkg::DIV_DEN_W'(r_ws)};
                        n_state = S_EX_DIVW;
                    end else begin
                        n_res[ridx] = div_rsp.quo[SW-1:0];
                        n_lane      = r_lane + 1'b1;
                        n_state     = S_EX_LANE;
                    end
                end
            end
            S_EX_DIVW: begin
                if (div_rsp.done) begin
                    n_res[ridx] = sat48(div_rsp.quo);
                    n_lane      = r_lane + 1'b1;
                    n_state     = S_EX_LANE;
                end
            end
            S_OUT: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_req    <= n_req;
        r_pix    <= n_pix;
        r_lane   <= n_lane;
        r_lim    <= n_lim;
        r_status <= n_status;
        r_cnt    <= n_cnt;
        r_ws     <= n_ws;
        r_prod   <= n_prod;
        r_band   <= n_band;
        r_res    <= n_res;
    end

    // hold the response until it is taken
    assign o_req_ready     = (r_state == S_IDLE) && !clr_busy;
    assign o_rsp_valid     = (r_state == S_OUT);
    assign o_rsp.status    = r_status;
    assign o_rsp.band_out0 = r_res[0];
    assign o_rsp.band_out1 = r_res[1];
    assign o_rsp.band_out2 = r_res[2];
    assign o_rsp.band_out3 = r_res[3];

endmodule

`default_nettype wire
